// File: rtl/core/ctpl_pkg.sv
`timescale 1ns / 1ps

package ctpl_pkg;

	// Table geometry
	localparam int SLOTS     = 32;
	localparam int KEY_BYTES = 32;
	localparam int WORD_W    = 64;
	localparam int KEY_W     = 4 * WORD_W;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int PLEN_W    = 6;
	localparam int ORD_W     = 8;
	localparam int TIME_W    = 32;
	localparam int PAY_W     = 32;

	typedef logic [KEY_W-1:0] key_t;

	// Operation codes
	typedef enum logic [1:0] {
		OP_UPSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	// Upsert outcome codes
	localparam logic [1:0] KIND_UPDATE = 2'd0;
	localparam logic [1:0] KIND_FREE   = 2'd1;
	localparam logic [1:0] KIND_EVICT  = 2'd2;

	// One stored record
	typedef struct packed {
		key_t              key;
		logic [TIME_W-1:0] rtime;
		logic [PAY_W-1:0]  payload;
	} rec_t;

	// Status from the shared compare unit
	typedef struct packed {
		logic key_eq;
		logic time_lt;
	} cmp_t;

	// Mask over the first nbytes key bytes; byte 0 sits in the top bits
	function automatic key_t prefix_mask(input logic [PLEN_W-1:0] nbytes);
		key_t m;
		m = '0;
		for (int b = 0; b < KEY_BYTES; b++) begin
			if (PLEN_W'(b) < nbytes) begin
				m[KEY_W-1-8*b -: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

	localparam key_t KEY_MASK = prefix_mask(PLEN_W'(KEY_BYTES));

endpackage

// File: rtl/core/ctpl_req_if.sv
`timescale 1ns / 1ps

interface ctpl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [63:0] key_w0;
	logic [63:0] key_w1;
	logic [63:0] key_w2;
	logic [63:0] key_w3;
	logic [5:0]  prefix_bytes;
	logic [31:0] record_time;
	logic [31:0] record_payload;
	logic [7:0]  ordinal;

	modport source (
		output valid, operation, key_w0, key_w1, key_w2, key_w3,
		output prefix_bytes, record_time, record_payload, ordinal,
		input  ready
	);
	modport sink (
		input  valid, operation, key_w0, key_w1, key_w2, key_w3,
		input  prefix_bytes, record_time, record_payload, ordinal,
		output ready
	);
endinterface

// File: rtl/core/ctpl_rsp_if.sv
`timescale 1ns / 1ps

interface ctpl_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [1:0]  upsert_kind;
	logic [4:0]  slot;
	logic [63:0] out_key_w0;
	logic [63:0] out_key_w1;
	logic [63:0] out_key_w2;
	logic [63:0] out_key_w3;
	logic [31:0] out_time;
	logic [31:0] out_payload;
	logic [5:0]  occupied_count;

	modport source (
		output valid, ok, upsert_kind, slot, out_key_w0, out_key_w1,
		output out_key_w2, out_key_w3, out_time, out_payload, occupied_count,
		input  ready
	);
	modport sink (
		input  valid, ok, upsert_kind, slot, out_key_w0, out_key_w1,
		input  out_key_w2, out_key_w3, out_time, out_payload, occupied_count,
		output ready
	);
endinterface

// File: rtl/core/ctpl_cmp.sv
`timescale 1ns / 1ps

// Shared compare unit: masked key match and timestamp order for one slot
module ctpl_cmp (
	input  ctpl_pkg::key_t                  row_key,
	input  ctpl_pkg::key_t                  key,
	input  ctpl_pkg::key_t                  mask,
	input  logic [ctpl_pkg::TIME_W-1:0]     row_time,
	input  logic [ctpl_pkg::TIME_W-1:0]     oldest,
	output ctpl_pkg::cmp_t                  res
);

	// Compare only the bytes under the mask
	assign res.key_eq  = ((row_key ^ key) & mask) == '0;
	// Strictly older keeps the lowest index on ties
	assign res.time_lt = row_time < oldest;

endmodule

// File: rtl/core/contact_table_prefix_lookup.sv
`timescale 1ns / 1ps

// Channel | Dir | Handshake    | Payload
// req     | in  | valid/ready  | operation, key_w0..3, prefix_bytes, record_time,
//         |     |              | record_payload, ordinal
// rsp     | out | valid/ready  | ok, upsert_kind, slot, out_key_w0..3, out_time,
//         |     |              | out_payload, occupied_count
//
// Each transaction scans one slot per cycle over all 32 slots through the single read
// port of the record memory, then passes a drain state for the registered memory read,
// a write-back state and the idle state, in which req.ready is high.
// arst_n clears the occupied flags, the count and the control state at once.
// A result held on rsp stalls write-back until rsp.ready; req.ready stays low.
module contact_table_prefix_lookup (
	input  logic        clk,
	input  logic        arst_n,
	ctpl_req_if.sink    req,
	ctpl_rsp_if.source  rsp
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	localparam logic [ctpl_pkg::SLOT_W-1:0] LAST_SLOT =
		ctpl_pkg::SLOT_W'(ctpl_pkg::SLOTS - 1);

	state_t                              state_q;
	ctpl_pkg::op_t                       op_q;
	ctpl_pkg::key_t                      key_q;
	ctpl_pkg::key_t                      mask_q;
	logic                                plen_bad_q;
	logic [ctpl_pkg::TIME_W-1:0]         time_q;
	logic [ctpl_pkg::PAY_W-1:0]          pay_q;
	logic [ctpl_pkg::ORD_W-1:0]          ord_q;

	logic [ctpl_pkg::SLOT_W-1:0]         idx_q;
	logic [ctpl_pkg::SLOT_W-1:0]         idx_s1;
	logic                                cmp_vld_s1;
	ctpl_pkg::rec_t                      rdata_s1;
	ctpl_pkg::rec_t                      rec_mem [ctpl_pkg::SLOTS];

	logic [ctpl_pkg::SLOTS-1:0]          occ_q;
	logic [ctpl_pkg::CNT_W-1:0]          cnt_q;
	logic [ctpl_pkg::CNT_W-1:0]          seen_q;

	logic                                hit_q;
	logic [ctpl_pkg::SLOT_W-1:0]         hit_idx_q;
	ctpl_pkg::rec_t                      hit_rec_q;
	logic                                free_q;
	logic [ctpl_pkg::SLOT_W-1:0]         free_idx_q;
	logic [ctpl_pkg::TIME_W-1:0]         oldest_q;
	logic [ctpl_pkg::SLOT_W-1:0]         oldest_idx_q;

	logic                                rsp_vld_q;
	logic                                ok_q;
	logic [1:0]                          kind_q;
	logic [ctpl_pkg::SLOT_W-1:0]         slot_q;
	ctpl_pkg::key_t                      okey_q;
	logic [ctpl_pkg::TIME_W-1:0]         otime_q;
	logic [ctpl_pkg::PAY_W-1:0]          opay_q;
	logic [ctpl_pkg::CNT_W-1:0]          ocnt_q;

	ctpl_pkg::cmp_t                      cmp;
	logic                                occ_s1;
	logic                                match_s1;
	logic                                req_fire;
	logic                                done_fire;
	logic [ctpl_pkg::SLOT_W-1:0]         up_idx;
	logic [1:0]                          up_kind;
	logic [ctpl_pkg::CNT_W-1:0]          cnt_nxt;
	ctpl_pkg::rec_t                      new_rec;
	logic                                is_upsert;
	logic                                is_remove;
	logic [ctpl_pkg::PLEN_W-1:0]         plen;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign plen      = req.prefix_bytes;

	// Shared compare unit over the slot coming out of memory
	ctpl_cmp u_cmp (
		.row_key  (rdata_s1.key),
		.key      (key_q),
		.mask     (mask_q),
		.row_time (rdata_s1.rtime),
		.oldest   (oldest_q),
		.res      (cmp)
	);

	assign occ_s1   = occ_q[idx_s1];
	assign match_s1 = (op_q == ctpl_pkg::OP_READ)
		? (occ_s1 && (ctpl_pkg::ORD_W'(seen_q) == ord_q))
		: (occ_s1 && cmp.key_eq && !plen_bad_q);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (req_fire) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_SLOT) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (done_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch the request and arm the scan
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q   <= ctpl_pkg::op_t'(req.operation);
			key_q  <= {req.key_w0, req.key_w1, req.key_w2, req.key_w3} & ctpl_pkg::KEY_MASK;
			time_q <= req.record_time;
			pay_q  <= req.record_payload;
			ord_q  <= req.ordinal;
			if (ctpl_pkg::op_t'(req.operation) == ctpl_pkg::OP_UPSERT) begin
				mask_q     <= ctpl_pkg::KEY_MASK;
				plen_bad_q <= 1'b0;
			end else begin
				mask_q     <= ctpl_pkg::prefix_mask(plen);
				plen_bad_q <= (plen == '0) ||
					(plen > ctpl_pkg::PLEN_W'(ctpl_pkg::KEY_BYTES));
			end
		end
	end

	// Record memory: one read per cycle, write on upsert
	always_ff @(posedge clk) begin
		if (done_fire && is_upsert) begin
			rec_mem[up_idx] <= new_rec;
		end
		rdata_s1 <= rec_mem[idx_q];
		idx_s1   <= idx_q;
	end

	// Track hit, first free slot, oldest slot and ordinal position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			seen_q       <= '0;
			oldest_q     <= '1;
			oldest_idx_q <= '0;
			hit_idx_q    <= '0;
			free_idx_q   <= '0;
		end else if (req_fire) begin
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			seen_q       <= '0;
			oldest_q     <= '1;
			oldest_idx_q <= '0;
		end else if (cmp_vld_s1) begin
			if (!hit_q && match_s1) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
			end
			if (!free_q && !occ_s1) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (occ_s1 && cmp.time_lt) begin
				oldest_q     <= rdata_s1.rtime;
				oldest_idx_q <= idx_s1;
			end
			if (occ_s1) begin
				seen_q <= seen_q + 1'b1;
			end
		end
	end

	// Hold the matching record
	always_ff @(posedge clk) begin
		if (cmp_vld_s1 && !hit_q && match_s1) begin
			hit_rec_q <= rdata_s1;
		end
	end

	// Resolve the write-back target and new count
	always_comb begin
		is_upsert = (op_q == ctpl_pkg::OP_UPSERT);
		is_remove = (op_q == ctpl_pkg::OP_REMOVE);
		done_fire = (state_q == ST_DONE) && (!rsp_vld_q || rsp.ready);
		new_rec.key     = key_q;
		new_rec.rtime   = time_q;
		new_rec.payload = pay_q;
		if (hit_q) begin
			up_idx  = hit_idx_q;
			up_kind = ctpl_pkg::KIND_UPDATE;
		end else if (free_q) begin
			up_idx  = free_idx_q;
			up_kind = ctpl_pkg::KIND_FREE;
		end else begin
			up_idx  = oldest_idx_q;
			up_kind = ctpl_pkg::KIND_EVICT;
		end
		cnt_nxt = cnt_q;
		if (is_upsert && (up_kind == ctpl_pkg::KIND_FREE)) begin
			cnt_nxt = cnt_q + 1'b1;
		end else if (is_remove && hit_q) begin
			cnt_nxt = cnt_q - 1'b1;
		end
	end

	// Occupied flags and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			cnt_q <= '0;
		end else if (done_fire) begin
			cnt_q <= cnt_nxt;
			if (is_upsert) begin
				occ_q[up_idx] <= 1'b1;
			end else if (is_remove && hit_q) begin
				occ_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	// Response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (done_fire) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (done_fire) begin
			ocnt_q <= cnt_nxt;
			if (is_upsert) begin
				ok_q    <= 1'b1;
				kind_q  <= up_kind;
				slot_q  <= up_idx;
				okey_q  <= key_q;
				otime_q <= time_q;
				opay_q  <= pay_q;
			end else if (hit_q) begin
				ok_q    <= 1'b1;
				kind_q  <= ctpl_pkg::KIND_UPDATE;
				slot_q  <= hit_idx_q;
				okey_q  <= hit_rec_q.key;
				otime_q <= hit_rec_q.rtime;
				opay_q  <= hit_rec_q.payload;
			end else begin
				ok_q    <= 1'b0;
				kind_q  <= ctpl_pkg::KIND_UPDATE;
				slot_q  <= '0;
				okey_q  <= '0;
				otime_q <= '0;
				opay_q  <= '0;
			end
		end
	end

	assign rsp.valid          = rsp_vld_q;
	assign rsp.ok             = ok_q;
	assign rsp.upsert_kind    = kind_q;
	assign rsp.slot           = slot_q;
	assign rsp.out_key_w0     = okey_q[4*ctpl_pkg::WORD_W-1 -: ctpl_pkg::WORD_W];
	assign rsp.out_key_w1     = okey_q[3*ctpl_pkg::WORD_W-1 -: ctpl_pkg::WORD_W];
	assign rsp.out_key_w2     = okey_q[2*ctpl_pkg::WORD_W-1 -: ctpl_pkg::WORD_W];
	assign rsp.out_key_w3     = okey_q[ctpl_pkg::WORD_W-1 -: ctpl_pkg::WORD_W];
	assign rsp.out_time       = otime_q;
	assign rsp.out_payload    = opay_q;
	assign rsp.occupied_count = ocnt_q;

endmodule

// File: rtl/core/ctpl_checker.sv
`timescale 1ns / 1ps

module ctpl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_ok,
	input logic [1:0] rsp_upsert_kind,
	input logic [4:0] rsp_slot,
	input logic [5:0] rsp_count
);

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// One transaction at a time: busy right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while a scan is running");

	// Count never exceeds the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= 6'(ctpl_pkg::SLOTS))
		else $error("occupied count out of range");

	// A miss reports slot and kind as zero
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> (rsp_slot == '0) &&
			(rsp_upsert_kind == ctpl_pkg::KIND_UPDATE))
		else $error("miss carries a slot or kind");

	// Free or evict outcomes always succeed and use a defined code
	a_kind_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp_upsert_kind == ctpl_pkg::KIND_FREE) ||
			(rsp_upsert_kind == ctpl_pkg::KIND_EVICT)) |-> rsp_ok)
		else $error("upsert outcome without success");

endmodule

bind contact_table_prefix_lookup ctpl_checker u_ctpl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_ok          (rsp.ok),
	.rsp_upsert_kind (rsp.upsert_kind),
	.rsp_slot        (rsp.slot),
	.rsp_count       (rsp.occupied_count)
);
